// ===== rtl/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// SM3 hash package
// Shared constants and round functions for the SM3 hash core.
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam logic [31:0] IV_WORDS [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };
    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] amt);
        logic [63:0] d;
        begin
            d = {v, v} << amt;
            rotl = d[63:32];
        end
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] v);
        perm0 = v ^ rotl(v, 5'd9) ^ rotl(v, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] v);
        perm1 = v ^ rotl(v, 5'd15) ^ rotl(v, 5'd23);
    endfunction

endpackage

// ===== rtl/sm3_round.sv =====
// ----------------------------------------------------------------------------
// SM3 compression round
// One round of the SM3 compression: new A..H from the current ones.
// ----------------------------------------------------------------------------
module sm3_round (
    input  logic [5:0]  round,
    input  logic [31:0] w_j,
    input  logic [31:0] wp_j,
    input  logic [31:0] cur [8],
    output logic [31:0] nxt [8]
);
    import sm3_pkg::*;

    logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2;

    always_comb
    begin
        a12 = rotl(cur[0], 5'd12);
        if (round < 6'd16)
        begin
            t  = rotl(T_LOW, round[4:0]);
            ff = cur[0] ^ cur[1] ^ cur[2];
            gg = cur[4] ^ cur[5] ^ cur[6];
        end
        else
        begin
            t  = rotl(T_HIGH, round[4:0]);
            ff = (cur[0] & cur[1]) | (cur[0] & cur[2]) | (cur[1] & cur[2]);
            gg = (cur[4] & cur[5]) | (~cur[4] & cur[6]);
        end
        ss1 = rotl(a12 + cur[4] + t, 5'd7);
        ss2 = ss1 ^ a12;
        tt1 = ff + cur[3] + ss2 + wp_j;
        tt2 = gg + cur[7] + ss1 + w_j;
        nxt[0] = tt1;
        nxt[1] = cur[0];
        nxt[2] = rotl(cur[1], 5'd9);
        nxt[3] = cur[2];
        nxt[4] = perm0(tt2);
        nxt[5] = cur[4];
        nxt[6] = rotl(cur[5], 5'd19);
        nxt[7] = cur[6];
    end

endmodule

// ===== rtl/sm3_hash_core.sv =====
// ----------------------------------------------------------------------------
// SM3 hash core
// Hashes a message given as 32-bit big-endian words and emits the digest.
// ----------------------------------------------------------------------------
// A word is taken while the core is idle and is written to the message
// memory at the current fill position. The sixteenth word of a block starts
// the compression: the load state reads the block from the memory into a
// 16-word expansion window, the round state runs the 64 rounds while the
// window shifts and produces the expanded words, and the fold state folds the
// result into the chaining value. The input is stalled while the block is
// compressed. On a last word the core writes the padding words one a cycle
// (up to 17 extra words, one or two blocks) and compresses them. It then
// presents the eight digest words in order, one per accepted result, and
// keeps the input stalled until the eighth word is taken.
module sm3_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_digest
);
    import sm3_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PAD  = 6'b000010,
        S_LOAD = 6'b000100,
        S_RND  = 6'b001000,
        S_FOLD = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    // Message word memory for the block being gathered.
    logic [31:0] wmem [16];
    logic [31:0] rd_data_reg;
    logic [31:0] chain_reg [8];
    logic [31:0] work_reg [8];
    logic [31:0] rnd_out [8];
    logic [31:0] win_reg [16];
    logic [63:0] bitlen_reg;
    logic [3:0]  fill_reg;
    logic [6:0]  cnt_reg;
    logic        final_reg;
    logic        mark_reg;
    logic        len_done_reg;
    logic [2:0]  oidx_reg;

    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [3:0]  rd_addr;
    logic [31:0] pad_word;
    logic [63:0] len_final;
    logic [2:0]  cnt_sat;

    // Window: win_reg[0] is W[j], win_reg[4] is W[j+4].
    logic [31:0] w_j, wp_j;
    assign w_j  = win_reg[0];
    assign wp_j = win_reg[0] ^ win_reg[4];

    sm3_round u_round (
        .round (cnt_reg[5:0]),
        .w_j   (w_j),
        .wp_j  (wp_j),
        .cur   (work_reg),
        .nxt   (rnd_out)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign digest_word = chain_reg[oidx_reg];
    assign word_index  = oidx_reg;
    assign last_digest = (oidx_reg == 3'd7);

    assign cnt_sat   = (byte_count > 3'd4) ? 3'd4 : byte_count;
    assign len_final = bitlen_reg + {58'd0, cnt_sat, 3'd0};

    // Expanded word W[j+16] from the fixed taps of the shifting window.
    logic [31:0] w16_j;
    assign w16_j = perm1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
                   ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];

    always_comb
    begin
        unique case (cnt_sat)
            3'd0:    pad_word = {PAD_BYTE, 24'd0};
            3'd1:    pad_word = {data_word[31:24], PAD_BYTE, 16'd0};
            3'd2:    pad_word = {data_word[31:16], PAD_BYTE, 8'd0};
            3'd3:    pad_word = {data_word[31:8], PAD_BYTE};
            default: pad_word = data_word;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        wr_en   = 1'b0;
        wr_addr = fill_reg;
        wr_data = 32'd0;
        rd_addr = 4'd0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    wr_en   = 1'b1;
                    wr_data = last_word ? pad_word : data_word;
                    if (last_word)
                        state_next = (fill_reg == 4'd15) ? S_LOAD : S_PAD;
                    else if (fill_reg == 4'd15)
                        state_next = S_LOAD;
                end
            end
            S_PAD:
            begin
                wr_en = 1'b1;
                if (mark_reg)
                    wr_data = {PAD_BYTE, 24'd0};
                else if (fill_reg == 4'd14)
                    wr_data = bitlen_reg[63:32];
                else if (fill_reg == 4'd15 && len_done_reg)
                    wr_data = bitlen_reg[31:0];
                if (fill_reg == 4'd15)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                rd_addr = cnt_reg[3:0];
                if (cnt_reg == 7'd16)
                    state_next = S_RND;
            end
            S_RND:
            begin
                if (cnt_reg == 7'd63)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                if (final_reg && len_done_reg)
                    state_next = S_OUT;
                else if (final_reg)
                    state_next = S_PAD;
                else
                    state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (!out_stall && oidx_reg == 3'd7)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            wmem[wr_addr] <= wr_data;
        rd_data_reg <= wmem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bitlen_reg   <= 64'd0;
            fill_reg     <= 4'd0;
            cnt_reg      <= 7'd0;
            final_reg    <= 1'b0;
            mark_reg     <= 1'b0;
            len_done_reg <= 1'b0;
            oidx_reg     <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV_WORDS[i];
                work_reg[i]  <= 32'd0;
            end
            for (int i = 0; i < 16; i++)
                win_reg[i] <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        fill_reg <= fill_reg + 4'd1;
                        cnt_reg  <= 7'd0;
                        if (last_word)
                        begin
                            bitlen_reg <= len_final;
                            final_reg  <= 1'b1;
                            // A full last word still needs its own 0x80 word.
                            mark_reg     <= (cnt_sat == 3'd4);
                            len_done_reg <= 1'b0;
                        end
                        else
                            bitlen_reg <= bitlen_reg + 64'd32;
                    end
                end
                S_PAD:
                begin
                    fill_reg <= fill_reg + 4'd1;
                    cnt_reg  <= 7'd0;
                    mark_reg <= 1'b0;
                    // Slot 14 without a pending marker word opens the length words.
                    if (!mark_reg && fill_reg == 4'd14)
                        len_done_reg <= 1'b1;
                end
                S_LOAD:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg != 7'd0)
                    begin
                        for (int i = 0; i < 15; i++)
                            win_reg[i] <= win_reg[i + 1];
                        win_reg[15] <= rd_data_reg;
                    end
                    if (cnt_reg == 7'd16)
                    begin
                        cnt_reg <= 7'd0;
                        for (int i = 0; i < 8; i++)
                            work_reg[i] <= chain_reg[i];
                    end
                end
                S_RND:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    for (int i = 0; i < 8; i++)
                        work_reg[i] <= rnd_out[i];
                    for (int i = 0; i < 15; i++)
                        win_reg[i] <= win_reg[i + 1];
                    win_reg[15] <= w16_j;
                end
                S_FOLD:
                begin
                    cnt_reg  <= 7'd0;
                    fill_reg <= 4'd0;
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] ^ work_reg[i];
                    if (final_reg && len_done_reg)
                        oidx_reg <= 3'd0;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= IV_WORDS[i];
                            bitlen_reg   <= 64'd0;
                            final_reg    <= 1'b0;
                            mark_reg     <= 1'b0;
                            len_done_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while digest is shown");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RND) |-> (cnt_reg < 7'd64))
        else $error("round counter out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(oidx_reg) && out_valid))
        else $error("digest index moved while stalled");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// SM3 hash core testbench
// Drives messages as big-endian words with random gaps and output stalls and
// checks every digest word against a behavioral SM3 computed in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import sm3_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_digest;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_t;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
        logic        known;
        logic [31:0] known_word0;
    } msg_row_t;

    localparam int DIR_ROWS = 24;
    localparam int RANDOM_ITEMS = 256;
    localparam int CYCLE_LIMIT = 400000;

    digest_t     digest_queue[$];
    logic [31:0] chain[8];
    logic [31:0] block_buf[16];
    logic [63:0] msg_bits;
    int          fill;
    int          errors;
    int          cycles;
    bit          stim_done;
    msg_row_t    dir_rows[DIR_ROWS];

    sm3_hash_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_word(data_word), .byte_count(byte_count), .last_word(last_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .digest_word(digest_word), .word_index(word_index),
        .last_digest(last_digest)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] rol(input logic [31:0] v, input int amt);
        int a;
        begin
            a = amt % 32;
            rol = (a == 0) ? v : ((v << a) | (v >> (32 - a)));
        end
    endfunction

    task automatic compress_chain();
        logic [31:0] w[68];
        logic [31:0] r[8];
        logic [31:0] ss1, ss2, tt1, tt2, ff, gg, t;
        begin
            for (int j = 0; j < 16; j++)
                w[j] = block_buf[j];
            for (int j = 16; j < 68; j++)
            begin
                t = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
                w[j] = (t ^ rol(t, 15) ^ rol(t, 23)) ^ rol(w[j-13], 7) ^ w[j-6];
            end
            for (int j = 0; j < 8; j++)
                r[j] = chain[j];
            for (int j = 0; j < 64; j++)
            begin
                if (j < 16)
                begin
                    t = rol(32'h79cc4519, j);
                    ff = r[0] ^ r[1] ^ r[2];
                    gg = r[4] ^ r[5] ^ r[6];
                end
                else
                begin
                    t = rol(32'h7a879d8a, j);
                    ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                    gg = (r[4] & r[5]) | (~r[4] & r[6]);
                end
                ss1 = rol(rol(r[0], 12) + r[4] + t, 7);
                ss2 = ss1 ^ rol(r[0], 12);
                tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
                tt2 = gg + r[7] + ss1 + w[j];
                r[3] = r[2];
                r[2] = rol(r[1], 9);
                r[1] = r[0];
                r[0] = tt1;
                r[7] = r[6];
                r[6] = rol(r[5], 19);
                r[5] = r[4];
                r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
            end
            for (int j = 0; j < 8; j++)
                chain[j] ^= r[j];
        end
    endtask

    task automatic append_word(input logic [31:0] v);
        begin
            block_buf[fill] = v;
            fill++;
            if (fill == 16)
            begin
                compress_chain();
                fill = 0;
            end
        end
    endtask

    task automatic reset_hash();
        begin
            for (int j = 0; j < 8; j++)
                chain[j] = IV_WORDS[j];
            msg_bits = '0;
            fill = 0;
        end
    endtask

    // Feeds one accepted item to the hash and queues any digest it finishes.
    task automatic hash_item(input logic [31:0] d, input logic [2:0] c, input logic l);
        int          n;
        logic [31:0] keep;
        digest_t     e;
        begin
            n = (c > 3'd4) ? 4 : int'(c);
            if (!l)
            begin
                msg_bits += 64'd32;
                append_word(d);
            end
            else
            begin
                msg_bits += 64'(8 * n);
                if (n < 4)
                begin
                    keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
                    append_word((d & keep) | (32'(PAD_BYTE) << (24 - 8 * n)));
                end
                else
                begin
                    append_word(d);
                    append_word(32'h80000000);
                end
                while (fill != 14)
                    append_word(32'h0);
                append_word(msg_bits[63:32]);
                append_word(msg_bits[31:0]);
                for (int j = 0; j < 8; j++)
                begin
                    e.word = chain[j];
                    e.index = 3'(j);
                    e.last = (j == 7);
                    digest_queue.push_back(e);
                end
                reset_hash();
            end
        end
    endtask

    task automatic send_item(input logic [31:0] d, input logic [2:0] c, input logic l);
        int gap;
        begin
            gap = ($urandom_range(0, 9) < 6) ? 0 :
                  (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            data_word <= d;
            byte_count <= c;
            last_word <= l;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            hash_item(d, c, l);
        end
    endtask

    initial
    begin
        int words;
        // Empty message; its first digest word is the well-known value.
        dir_rows[0] = '{32'h0, 3'd0, 1'b1, 1'b1, 32'h1ab21d83};
        // "abc" in one partial last word.
        dir_rows[1] = '{32'h616263ff, 3'd3, 1'b1, 1'b1, 32'h66c7f0f4};
        dir_rows[2] = '{32'hffffffff, 3'd1, 1'b1, 1'b0, 32'h0};
        dir_rows[3] = '{32'hffffffff, 3'd2, 1'b1, 1'b0, 32'h0};
        dir_rows[4] = '{32'hffffffff, 3'd4, 1'b1, 1'b0, 32'h0};
        // Byte count above four is treated as four.
        dir_rows[5] = '{32'h12345678, 3'd7, 1'b1, 1'b0, 32'h0};
        dir_rows[6] = '{32'h00000000, 3'd5, 1'b1, 1'b0, 32'h0};
        // Partial counts on non-last words are taken as full words.
        for (int k = 7; k < 20; k++)
            dir_rows[k] = '{(k[0] ? 32'hffffffff : 32'h0), 3'(k % 8), 1'b0, 1'b0, 32'h0};
        // Thirteen body words, then a full last word: two padding blocks.
        dir_rows[20] = '{32'hdeadbeef, 3'd4, 1'b1, 1'b0, 32'h0};
        dir_rows[21] = '{32'h80000001, 3'd6, 1'b0, 1'b0, 32'h0};
        dir_rows[22] = '{32'h7fffffff, 3'd3, 1'b0, 1'b0, 32'h0};
        dir_rows[23] = '{32'h55aa55aa, 3'd2, 1'b1, 1'b0, 32'h0};

        errors = 0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_word = '0;
        byte_count = '0;
        last_word = 1'b0;
        reset_hash();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIR_ROWS; k++)
        begin
            send_item(dir_rows[k].data, dir_rows[k].count, dir_rows[k].last);
            if (dir_rows[k].known && digest_queue.size() >= 8 &&
                digest_queue[digest_queue.size() - 8].word != dir_rows[k].known_word0)
            begin
                $display("%0t: digest word 0 expected %h, predicted %h", $time,
                         dir_rows[k].known_word0, digest_queue[digest_queue.size() - 8].word);
                errors++;
            end
        end

        // Random messages: mostly short, a few spanning several blocks.
        words = 0;
        while (words < RANDOM_ITEMS)
        begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 18);
            for (int k = 0; k < len; k++)
            begin
                send_item($urandom, 3'($urandom_range(0, 7)), 1'b0);
                words++;
            end
            send_item($urandom, 3'($urandom_range(0, 7)), 1'b1);
            words++;
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stalls; one long hold-off while messages keep coming.
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n);
        repeat (3000) @(posedge clk);
        for (int k = 0; k < 1500; k++)
        begin
            @(posedge clk);
            out_stall <= 1'b1;
        end
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 49) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(5, 30)) @(posedge clk);
            end
            else if ($urandom_range(0, 9) < 3)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 9) < 8 || 1)
                out_stall <= ($urandom_range(0, 99) < 5);
        end
    end

    always @(posedge clk)
    begin
        digest_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_queue.size() == 0)
            begin
                $display("%0t: unexpected digest word %h index %0d", $time,
                         digest_word, word_index);
                errors++;
            end
            else
            begin
                e = digest_queue.pop_front();
                if (digest_word !== e.word || word_index !== e.index ||
                    last_digest !== e.last)
                begin
                    $display("%0t: expected word %h index %0d last %b, got %h %0d %b",
                             $time, e.word, e.index, e.last,
                             digest_word, word_index, last_digest);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (!(stim_done && digest_queue.size() == 0) && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL sm3_hash_core");
        end
        else
        begin
            repeat (200) @(posedge clk);
            if (errors == 0 && digest_queue.size() == 0)
                $display("PASS sm3_hash_core");
            else
                $display("FAIL sm3_hash_core");
        end
        $finish;
    end
endmodule

// ===== sm3_hash_core.f =====
rtl/sm3_pkg.sv
rtl/sm3_round.sv
rtl/sm3_hash_core.sv
tb/tb_top.sv
